FILE: hdl/tsr_pkg.sv
// Shared types and constants for the scanline triangle rasterizer.
// Used by the serial divider and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    localparam int COORD_W    = 16;
    localparam int COORD_FRAC = 4;
    localparam int SLOPE_FRAC = 16;
    localparam int PIX_W      = 12;
    localparam int SLOPE_W    = 32;
    localparam int MUL_A_W    = 19;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_NUM_W  = 36;
    localparam int DIV_DEN_W  = 18;

    localparam logic [1:0] PART_NONE  = 2'd0;
    localparam logic [1:0] PART_UPPER = 2'd1;
    localparam logic [1:0] PART_LOWER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_MUL,
        S_LD_DIVS,
        S_LD_DIVW,
        S_SETUP,
        S_SL_START,
        S_SL_WAIT,
        S_SR_START,
        S_SR_WAIT,
        S_ST_MUL_L,
        S_ST_COL_L,
        S_ST_MUL_R,
        S_ST_COL_R,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: hdl/tsr_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on tsr_pkg for the request and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tsr_div import tsr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    output t_div_stat            o_stat,
    output logic [DIV_NUM_W-1:0] o_quot,
    output logic [DIV_DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W+1:0] w_trial;
    logic                 w_fit;

    assign w_shift = {r_rem, r_quot[DIV_NUM_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};
    assign w_fit   = ~w_trial[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.num;
            r_rem  <= '0;
            r_den  <= i_req.den;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_NUM_W-2:0], w_fit};
            r_rem  <= w_fit ? w_trial[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

FILE: hdl/triangle_scanline_rasterizer.sv
// Top level of the scanline triangle rasterizer: sequencer, shared multiplier,
// edge and setup datapath. Depends on tsr_pkg and instantiates tsr_div.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one word per
// request. A word with i_func = 0 loads three vertices in signed 12.4 fixed
// point; the block sorts them by y, finds the split point on the long edge
// and sets up the upper part, or the lower part when the upper one covers no
// row. A word with i_func = 1 asks for the next scanline span. Every input
// word yields exactly one output word on o_out_valid / i_out_stall.
// A load that covers a row runs the split divide and both slope divides in
// the one serial divider, and each divide holds the sequencer until it is
// done. A span takes two multiplier passes and two column adds; the span
// that closes the upper part sets up the lower one. A step with nothing
// loaded goes straight to the response state.
// The block holds o_in_stall high while it works on a word. The result sits
// in an output register; if the receiver stalls, the sequencer waits in its
// response state, and the output word does not change while stalled.
// Reset clears the sequencer, the output valid and the loaded-part state, so
// a step right after reset returns done.
`timescale 1ns / 1ps
`default_nettype none

module triangle_scanline_rasterizer import tsr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic signed [COORD_W-1:0] i_ax,
    input  logic signed [COORD_W-1:0] i_ay,
    input  logic signed [COORD_W-1:0] i_bx,
    input  logic signed [COORD_W-1:0] i_by_coord,
    input  logic signed [COORD_W-1:0] i_cx,
    input  logic signed [COORD_W-1:0] i_cy,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_span_valid,
    output logic signed [PIX_W-1:0] o_span_row,
    output logic signed [PIX_W-1:0] o_span_x_start,
    output logic signed [PIX_W-1:0] o_span_x_end,
    output logic                    o_last_span,
    output logic                    o_done_res
);

    t_state r_state, n_state;

    // Sorted vertices, split x, per-part edge state.
    logic signed [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [COORD_W-1:0] r_split_x;
    logic signed [SLOPE_W-1:0] r_lslope, r_rslope;
    logic signed [PIX_W-1:0]   r_row, r_end;
    logic [1:0]                r_phase;
    logic [1:0]                r_part;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PIX_W-1:0]   r_xs, r_xe, r_span_row;
    logic                      r_is_span;

    logic                    r_out_valid;
    logic                    r_o_span_valid;
    logic signed [PIX_W-1:0] r_o_row, r_o_xs, r_o_xe;
    logic                    r_o_last, r_o_done;

    logic w_accept;
    logic w_resp_go;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_resp_go = !r_out_valid || !i_out_stall;

    // Three compare-exchange steps sort the incoming vertices by y; equal y
    // keeps the input order.
    logic signed [COORD_W-1:0] s_x [3];
    logic signed [COORD_W-1:0] s_y [3];

    always_comb begin
        logic signed [COORD_W-1:0] tx, ty;
        tx = '0;
        ty = '0;
        s_x[0] = i_ax; s_y[0] = i_ay;
        s_x[1] = i_bx; s_y[1] = i_by_coord;
        s_x[2] = i_cx; s_y[2] = i_cy;
        if (s_y[0] > s_y[1]) begin
            tx = s_x[0]; ty = s_y[0];
            s_x[0] = s_x[1]; s_y[0] = s_y[1];
            s_x[1] = tx; s_y[1] = ty;
        end
        if (s_y[1] > s_y[2]) begin
            tx = s_x[1]; ty = s_y[1];
            s_x[1] = s_x[2]; s_y[1] = s_y[2];
            s_x[2] = tx; s_y[2] = ty;
        end
        if (s_y[0] > s_y[1]) begin
            tx = s_x[0]; ty = s_y[0];
            s_x[0] = s_x[1]; s_y[0] = s_y[1];
            s_x[1] = tx; s_y[1] = ty;
        end
    end

    // Row index of the first pixel centre at or below a y coordinate:
    // ceil(v - 0.5) in whole pixels.
    function automatic logic signed [PIX_W+1:0] centre_ceil(
        input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W+1:0] t;
        t = {v[COORD_W-1], v, 1'b0} + (COORD_W+2)'((1 << COORD_FRAC) - 1);
        return (PIX_W+2)'(t >>> (COORD_FRAC + 1));
    endfunction

    // Edge endpoints of the selected part. The middle vertex and the split
    // point are ordered so the one further left bounds the left edge.
    logic                      w_v1left, w_upper;
    logic signed [COORD_W-1:0] w_lx, w_rx;
    logic signed [COORD_W-1:0] w_lrx, w_lry, w_ltx, w_lty;
    logic signed [COORD_W-1:0] w_rrx, w_rry, w_rtx, w_rty;

    assign w_v1left = r_x1 < r_split_x;
    assign w_lx     = w_v1left ? r_x1 : r_split_x;
    assign w_rx     = w_v1left ? r_split_x : r_x1;
    assign w_upper  = r_part == PART_UPPER;
    assign w_lrx    = w_upper ? r_x0 : w_lx;
    assign w_lry    = w_upper ? r_y0 : r_y1;
    assign w_ltx    = w_upper ? w_lx : r_x2;
    assign w_lty    = w_upper ? r_y1 : r_y2;
    assign w_rrx    = w_upper ? r_x0 : w_rx;
    assign w_rry    = w_upper ? r_y0 : r_y1;
    assign w_rtx    = w_upper ? w_rx : r_x2;
    assign w_rty    = w_upper ? r_y1 : r_y2;

    // Row range of the selected part.
    logic signed [PIX_W+1:0] w_first, w_last;
    logic                    w_part_ok;

    assign w_first   = centre_ceil(w_upper ? r_y0 : r_y1);
    assign w_last    = centre_ceil(w_upper ? r_y1 : r_y2) - (PIX_W+2)'(1);
    assign w_part_ok = w_first <= w_last;

    // Slope divide operands: (dx << SLOPE_FRAC) / dy, sign handled outside.
    logic                    w_sel_right;
    logic signed [COORD_W:0] w_dx, w_dy;
    logic                    w_slope_neg;
    logic [COORD_W+SLOPE_FRAC:0] w_slope_num, w_slope_abs;

    assign w_sel_right = (r_state == S_SR_START) || (r_state == S_SR_WAIT);
    assign w_dx = w_sel_right ? ({w_rtx[COORD_W-1], w_rtx} - {w_rrx[COORD_W-1], w_rrx})
                              : ({w_ltx[COORD_W-1], w_ltx} - {w_lrx[COORD_W-1], w_lrx});
    assign w_dy = w_sel_right ? ({w_rty[COORD_W-1], w_rty} - {w_rry[COORD_W-1], w_rry})
                              : ({w_lty[COORD_W-1], w_lty} - {w_lry[COORD_W-1], w_lry});
    assign w_slope_neg = w_dx[COORD_W];
    assign w_slope_num = {w_dx, {SLOPE_FRAC{1'b0}}};
    assign w_slope_abs = w_slope_neg ? -w_slope_num : w_slope_num;

    // Split divide: round((y1-y0)(x2-x0) / (y2-y0)) as
    // floor((2p + den) / (2 den)).
    logic signed [COORD_W:0]  w_sden, w_dy1, w_dx2;
    logic signed [37:0]       w_split_num;
    logic                     w_split_neg;
    logic [37:0]              w_split_abs;

    assign w_sden      = {r_y2[COORD_W-1], r_y2} - {r_y0[COORD_W-1], r_y0};
    assign w_dy1       = {r_y1[COORD_W-1], r_y1} - {r_y0[COORD_W-1], r_y0};
    assign w_dx2       = {r_x2[COORD_W-1], r_x2} - {r_x0[COORD_W-1], r_x0};
    assign w_split_num = {r_prod[36:0], 1'b0} + {{21{w_sden[COORD_W]}}, w_sden};
    assign w_split_neg = w_split_num[37];
    assign w_split_abs = w_split_neg ? -w_split_num : w_split_num;

    // Shared divider.
    t_div_req             w_div_req;
    t_div_stat            w_div_stat;
    logic [DIV_NUM_W-1:0] w_quot;
    logic [DIV_DEN_W-1:0] w_rem;
    logic                 w_div_split;

    assign w_div_split = (r_state == S_LD_DIVS) || (r_state == S_LD_DIVW);

    tsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Split result: floor toward minus infinity, then clamp to coordinates.
    logic signed [37:0]        w_split_q, w_split_sum;
    logic signed [COORD_W-1:0] w_split_x;

    assign w_split_q   = w_split_neg ? -({2'b00, w_quot} + 38'(|w_rem))
                                     : {2'b00, w_quot};
    assign w_split_sum = {{22{r_x0[COORD_W-1]}}, r_x0} + w_split_q;

    always_comb begin
        if (w_split_sum > 38'sd32767) begin
            w_split_x = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (w_split_sum < -38'sd32768) begin
            w_split_x = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_split_x = w_split_sum[COORD_W-1:0];
        end
    end

    // Slope result: truncation toward zero, saturated to 32 bits.
    logic signed [SLOPE_W-1:0] w_slope;

    always_comb begin
        if (w_dy <= 0) begin
            w_slope = '0;
        end else if (!w_slope_neg) begin
            w_slope = (w_quot > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : w_quot[SLOPE_W-1:0];
        end else begin
            w_slope = (w_quot > 36'h080000000) ? 32'sh80000000 : -w_quot[SLOPE_W-1:0];
        end
    end

    // Shared multiplier: split product during load, edge offset times slope
    // during a step. The offset is 2*(row + 0.5) - 2*yref in coordinate units.
    logic signed [MUL_A_W-1:0] w_yc2, w_doff, w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_mul_right;
    logic signed [COORD_W-1:0] w_yref;

    assign w_mul_right = r_state == S_ST_MUL_R;
    assign w_yref = w_mul_right ? w_rry : w_lry;
    assign w_yc2  = {r_row[PIX_W-1], r_row[PIX_W-1], r_row, 1'b1, {COORD_FRAC{1'b0}}};
    assign w_doff = w_yc2 - {{2{w_yref[COORD_W-1]}}, w_yref, 1'b0};
    assign w_ma   = (r_state == S_LD_MUL) ? {{2{w_dy1[COORD_W]}}, w_dy1} : w_doff;
    assign w_mb   = (r_state == S_LD_MUL) ? {{15{w_dx2[COORD_W]}}, w_dx2}
                  : (w_mul_right ? r_rslope : r_lslope);
    assign w_prod = w_ma * w_mb;

    // Edge column: ceil(x - 0.5) at the row centre, clamped to pixel range.
    logic signed [COORD_W-1:0] w_xref;
    logic signed [51:0]        w_xv, w_xr, w_xsh;
    logic signed [PIX_W-1:0]   w_col;

    assign w_xref = (r_state == S_ST_COL_R) ? w_rrx : w_lrx;
    assign w_xv   = {{19{w_xref[COORD_W-1]}}, w_xref, 17'b0} + {r_prod[PROD_W-1], r_prod}
                  - 52'sd1048576;
    assign w_xr   = w_xv + 52'sd2097151;
    assign w_xsh  = w_xr >>> (COORD_FRAC + 1 + SLOPE_FRAC);

    always_comb begin
        if (w_xsh > 52'sd2047) begin
            w_col = 12'sh7FF;
        end else if (w_xsh < -52'sd2048) begin
            w_col = 12'sh800;
        end else begin
            w_col = w_xsh[PIX_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_func) begin
                        n_state = S_LD_MUL;
                    end else if (r_phase == PART_NONE) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_ST_MUL_L;
                    end
                end
            end
            S_LD_MUL:   n_state = (w_sden > 0) ? S_LD_DIVS : S_SETUP;
            S_LD_DIVS:  n_state = S_LD_DIVW;
            S_LD_DIVW:  n_state = w_div_stat.done ? S_SETUP : S_LD_DIVW;
            S_SETUP: begin
                if (w_part_ok) begin
                    n_state = S_SL_START;
                end else if (r_part == PART_UPPER) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SL_START: n_state = S_SL_WAIT;
            S_SL_WAIT:  n_state = w_div_stat.done ? S_SR_START : S_SL_WAIT;
            S_SR_START: n_state = S_SR_WAIT;
            S_SR_WAIT:  n_state = w_div_stat.done ? S_RESP : S_SR_WAIT;
            S_ST_MUL_L: n_state = S_ST_COL_L;
            S_ST_COL_L: n_state = S_ST_MUL_R;
            S_ST_MUL_R: n_state = S_ST_COL_R;
            S_ST_COL_R: begin
                if (r_row >= r_end && r_part == PART_UPPER) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP:     n_state = w_resp_go ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall      = 1'b1;
        w_div_req.start = 1'b0;
        w_div_req.num   = {3'b000, w_slope_abs};
        w_div_req.den   = {1'b0, w_dy};
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_LD_DIVS: begin
                w_div_req.start = 1'b1;
            end
            S_SL_START, S_SR_START: begin
                w_div_req.start = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        if (w_div_split) begin
            w_div_req.num = w_split_abs[DIV_NUM_W-1:0];
            w_div_req.den = {w_sden, 1'b0};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PART_NONE;
            r_part      <= PART_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_func) begin
                            r_phase <= PART_NONE;
                            r_part  <= PART_UPPER;
                        end else begin
                            r_part <= r_phase;
                        end
                    end
                end
                S_SETUP: begin
                    if (!w_part_ok) begin
                        if (r_part == PART_UPPER) begin
                            r_part <= PART_LOWER;
                        end else begin
                            r_phase <= PART_NONE;
                        end
                    end
                end
                S_SR_WAIT: begin
                    if (w_div_stat.done) begin
                        r_phase <= r_part;
                    end
                end
                S_ST_COL_R: begin
                    if (r_row >= r_end) begin
                        if (r_part == PART_UPPER) begin
                            r_part <= PART_LOWER;
                        end else begin
                            r_phase <= PART_NONE;
                        end
                    end
                end
                default: begin
                    r_part <= r_part;
                end
            endcase
            if (r_state == S_RESP && w_resp_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_is_span <= i_func && (r_phase != PART_NONE);
                    if (!i_func) begin
                        r_x0 <= s_x[0]; r_y0 <= s_y[0];
                        r_x1 <= s_x[1]; r_y1 <= s_y[1];
                        r_x2 <= s_x[2]; r_y2 <= s_y[2];
                    end
                end
            end
            S_LD_MUL: begin
                r_prod    <= w_prod;
                r_split_x <= r_x0;
            end
            S_LD_DIVW: begin
                if (w_div_stat.done) begin
                    r_split_x <= w_split_x;
                end
            end
            S_SETUP: begin
                if (w_part_ok) begin
                    r_row <= w_first[PIX_W-1:0];
                    r_end <= w_last[PIX_W-1:0];
                end
            end
            S_SL_WAIT: begin
                if (w_div_stat.done) begin
                    r_lslope <= w_slope;
                end
            end
            S_SR_WAIT: begin
                if (w_div_stat.done) begin
                    r_rslope <= w_slope;
                end
            end
            S_ST_MUL_L, S_ST_MUL_R: begin
                r_prod <= w_prod;
            end
            S_ST_COL_L: begin
                r_xs <= w_col;
            end
            S_ST_COL_R: begin
                r_xe       <= w_col;
                r_span_row <= r_row;
                if (r_row < r_end) begin
                    r_row <= r_row + PIX_W'(1);
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // Output word register; span fields read as zero on non-span words.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && w_resp_go) begin
            r_o_span_valid <= r_is_span;
            r_o_row        <= r_is_span ? r_span_row : '0;
            r_o_xs         <= r_is_span ? r_xs : '0;
            r_o_xe         <= r_is_span ? r_xe : '0;
            r_o_last       <= r_is_span && (r_phase == PART_NONE);
            r_o_done       <= r_phase == PART_NONE;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_span_valid   = r_o_span_valid;
    assign o_span_row     = r_o_row;
    assign o_span_x_start = r_o_xs;
    assign o_span_x_end   = r_o_xe;
    assign o_last_span    = r_o_last;
    assign o_done_res     = r_o_done;

    // The final span flag always comes with done.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_span == (o_span_valid && o_done_res)))
        else $error("last span without matching done");

    // The divider is only started when idle.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // A divide only finishes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_LD_DIVW || r_state == S_SL_WAIT ||
                             r_state == S_SR_WAIT))
        else $error("divide result arrived outside a wait state");

endmodule

`default_nettype wire
